FILE: rtl/pnrl_pkg.sv
package pnrl_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
   localparam logic [WORD_W-1:0] RATE_LIMIT_RESET = 32'd60000;
   localparam logic [WORD_W-1:0] NODE_INVALID = 32'd0;

   typedef logic [WORD_W-1:0] word_type;

   // result of the age unit
   typedef struct packed {
      word_type age;
      logic     ge_limit;
      logic     gt_oldest;
   } age_res_type;

endpackage

FILE: rtl/pnrl_intf.sv
interface pnrl_req_if;
   import pnrl_pkg::*;

   logic     valid;
   logic     ready;
   word_type node_id;
   word_type now_ms;

   modport source (output valid, output node_id, output now_ms, input ready);
   modport sink (input valid, input node_id, input now_ms, output ready);
endinterface

interface pnrl_rsp_if;
   logic valid;
   logic ready;
   logic send_ok;

   modport source (output valid, output send_ok, input ready);
   modport sink (input valid, input send_ok, output ready);
endinterface

FILE: rtl/per_node_rate_limit_table_unit.sv
// per-node rate limiter with a table of TABLE_DEPTH nodes
// req channel: valid/ready with node_id and now_ms; a request is taken when
//   valid and ready are high at a rising clock edge
// rsp channel: valid/ready with send_ok, one response per request
// csr port: csr_wr_en/csr_wr_data write rate_limit_ms; users must write
//   only while idle, the block does not enforce it; a request for node zero
//   or against an empty table answers in the cycle after it is taken
// otherwise the table is scanned through its single read port, one entry per
//   cycle with a registered read, matching the node and tracking the oldest
//   entry at the same time
// ready stays low from the taking of a request until its response is taken,
//   so no new request is taken until the unit has returned to idle
// reset clears the fill count and sets rate_limit_ms to 60000; no clearing
//   pass is needed, entries are read only below the fill count
// a stalled response holds valid and send_ok until ready rises
module per_node_rate_limit_table_unit #(
   parameter int unsigned TABLE_DEPTH = pnrl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   pnrl_req_if.sink           req_ch,
   pnrl_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  pnrl_pkg::word_type csr_wr_data
);
   import pnrl_pkg::*;

   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   word_type      rate_limit_ff;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   word_type      rd_node;
   word_type      rd_time;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   word_type      wr_node;
   word_type      wr_time;
   logic [CW-1:0] fill_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_limit_ff <= RATE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         rate_limit_ff <= csr_wr_data;
      end
   end

   pnrl_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_node   (req_ch.node_id),
      .req_now    (req_ch.now_ms),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .send_ok    (rsp_ch.send_ok),
      .rate_limit (rate_limit_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_node    (rd_node),
      .rd_time    (rd_time),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_node    (wr_node),
      .wr_time    (wr_time),
      .fill_count (fill_count)
   );

   pnrl_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_node (rd_node),
      .rd_time (rd_time),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_node (wr_node),
      .wr_time (wr_time)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ch.valid && req_ch.ready))
      else $error("request taken while a response is pending");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready stayed high after a request was taken");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count <= CW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // the table only grows, by at most one entry per request
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (fill_count != $past(fill_count)))
      |-> (fill_count == ($past(fill_count) + CW'(1))))
      else $error("fill count changed by other than one");

   a_table_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_ch.valid)
      else $error("table written without a response following");
endmodule

FILE: rtl/pnrl_age_unit.sv
module pnrl_age_unit (
   input  pnrl_pkg::word_type    now_ms,
   input  pnrl_pkg::word_type    last_ms,
   input  pnrl_pkg::word_type    limit_ms,
   input  pnrl_pkg::word_type    oldest_age,
   output pnrl_pkg::age_res_type res
);
   import pnrl_pkg::*;

   word_type age;

   // wrapping age of one entry
   assign age           = now_ms - last_ms;
   assign res.age       = age;
   assign res.ge_limit  = (age >= limit_ms);
   assign res.gt_oldest = (age > oldest_age);
endmodule

FILE: rtl/pnrl_table.sv
module pnrl_table #(
   parameter int unsigned TABLE_DEPTH = pnrl_pkg::TABLE_DEPTH_DEFAULT,
   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [IW-1:0]      rd_addr,
   output pnrl_pkg::word_type rd_node,
   output pnrl_pkg::word_type rd_time,
   input  logic               wr_en,
   input  logic [IW-1:0]      wr_addr,
   input  pnrl_pkg::word_type wr_node,
   input  pnrl_pkg::word_type wr_time
);
   import pnrl_pkg::*;

   word_type mem_node_ff [TABLE_DEPTH];
   word_type mem_time_ff [TABLE_DEPTH];
   word_type rd_node_ff;
   word_type rd_time_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_node_ff[wr_addr] <= wr_node;
         mem_time_ff[wr_addr] <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_node_ff <= mem_node_ff[rd_addr];
         rd_time_ff <= mem_time_ff[rd_addr];
      end
   end

   assign rd_node = rd_node_ff;
   assign rd_time = rd_time_ff;
endmodule

FILE: rtl/pnrl_ctrl.sv
module pnrl_ctrl #(
   parameter int unsigned TABLE_DEPTH = pnrl_pkg::TABLE_DEPTH_DEFAULT,
   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pnrl_pkg::word_type req_node,
   input  pnrl_pkg::word_type req_now,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               send_ok,
   input  pnrl_pkg::word_type rate_limit,
   output logic               rd_en,
   output logic [IW-1:0]      rd_addr,
   input  pnrl_pkg::word_type rd_node,
   input  pnrl_pkg::word_type rd_time,
   output logic               wr_en,
   output logic [IW-1:0]      wr_addr,
   output pnrl_pkg::word_type wr_node,
   output pnrl_pkg::word_type wr_time,
   output logic [CW-1:0]      fill_count
);
   import pnrl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic        pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [IW-1:0] victim_ff, victim_in;
   word_type    oldest_ff, oldest_in;
   word_type    node_ff, node_in;
   word_type    now_ff, now_in;
   logic        ok_ff, ok_in;

   age_res_type age_res;
   logic        hit;
   logic        last;
   logic        take;
   logic        full;
   logic [IW-1:0] victim_sel;

   pnrl_age_unit u_age (
      .now_ms     (now_ff),
      .last_ms    (rd_time),
      .limit_ms   (rate_limit),
      .oldest_age (oldest_ff),
      .res        (age_res)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign send_ok    = ok_ff;
   assign fill_count = fill_ff;

   assign rd_en   = (state_ff == ST_SCAN) && (issue_ff < fill_ff);
   assign rd_addr = issue_ff[IW-1:0];

   assign hit        = pend_ff && (rd_node == node_ff);
   assign last       = (CW'(pend_idx_ff) == (fill_ff - CW'(1)));
   assign take       = (pend_idx_ff == '0) || age_res.gt_oldest;
   assign victim_sel = take ? pend_idx_ff : victim_ff;
   assign full       = (fill_ff == CW'(TABLE_DEPTH));

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      victim_in   = victim_ff;
      oldest_in   = oldest_ff;
      node_in     = node_ff;
      now_in      = now_ff;
      ok_in       = ok_ff;
      wr_en       = 1'b0;
      wr_addr     = pend_idx_ff;
      wr_node     = node_ff;
      wr_time     = now_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               node_in  = req_node;
               now_in   = req_now;
               issue_in = '0;
               if (req_node == NODE_INVALID) begin
                  ok_in    = 1'b0;
                  state_in = ST_RESP;
               end else if (fill_ff == '0) begin
                  // empty table, append at the first entry
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_node  = req_node;
                  wr_time  = req_now;
                  fill_in  = CW'(1);
                  ok_in    = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
            end
            if (hit) begin
               ok_in    = age_res.ge_limit;
               wr_en    = age_res.ge_limit;
               wr_addr  = pend_idx_ff;
               pend_in  = 1'b0;
               state_in = ST_RESP;
            end else if (pend_ff) begin
               if (take) begin
                  oldest_in = age_res.age;
                  victim_in = pend_idx_ff;
               end
               if (last) begin
                  wr_en    = 1'b1;
                  ok_in    = 1'b1;
                  pend_in  = 1'b0;
                  state_in = ST_RESP;
                  if (!full) begin
                     wr_addr = fill_ff[IW-1:0];
                     fill_in = fill_ff + CW'(1);
                  end else begin
                     wr_addr = victim_sel;
                  end
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      victim_ff   <= victim_in;
      oldest_ff   <= oldest_in;
      node_ff     <= node_in;
      now_ff      <= now_in;
      ok_ff       <= ok_in;
   end
endmodule
